// ----- rtl/rdp_connection_request_token_parser_assert.svh -----
// Assertion macros for the connection request token parser.
`ifndef RDP_CONNECTION_REQUEST_TOKEN_PARSER_ASSERT_SVH
`define RDP_CONNECTION_REQUEST_TOKEN_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define RDPTOK_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rdptok: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define RDPTOK_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rdptok: next-cycle check failed");

`endif

// ----- rtl/rdptok_pkg.sv -----
// Types and protocol constants for the connection request token parser.
`default_nettype none

package rdptok_pkg;

    // Sequencer states
    typedef enum logic {
        S_RUN,
        S_TOKEN
    } rdptok_state_t;

    // Result item kinds
    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_TOKEN   = 1'b1;

    // Verdict codes
    localparam logic [1:0] VERDICT_MALFORMED = 2'd0;
    localparam logic [1:0] VERDICT_NORMAL    = 2'd1;
    localparam logic [1:0] VERDICT_TOKEN     = 2'd2;

    // Header byte offsets
    localparam logic [15:0] OFF_VERSION  = 16'd0;
    localparam logic [15:0] OFF_RESERVED = 16'd1;
    localparam logic [15:0] OFF_LEN_HI   = 16'd2;
    localparam logic [15:0] OFF_LEN_LO   = 16'd3;
    localparam logic [15:0] OFF_TPDU     = 16'd5;
    localparam logic [15:0] OFF_LAST_HDR = 16'd10;
    localparam logic [15:0] OFF_VARIABLE = 16'd11;

    // Header values
    localparam logic [7:0]  TPKT_VERSION  = 8'h03;
    localparam logic [7:0]  TPKT_RESERVED = 8'h00;
    localparam logic [15:0] MIN_PKT_LEN   = 16'd11;
    localparam logic [7:0]  X224_CR_CODE  = 8'hE0;

    // Negotiation request signature
    localparam logic [7:0]  NEG_TYPE    = 8'h01;
    localparam logic [7:0]  NEG_LEN_LO  = 8'h08;
    localparam logic [7:0]  NEG_LEN_HI  = 8'h00;
    localparam logic [15:0] NEG_MIN_PKT = 16'd19;

    // Line end characters
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

endpackage

`default_nettype wire

// ----- rtl/rdp_connection_request_token_parser.sv -----
// Top level: TPKT / X.224 connection request parser with routing token readout.
// Usage:
//   Input channel (s_valid/s_ready): one byte of the connection stream per item;
//   s_new_connection marks offset 0 of a new packet and drops any partial one.
//   Bytes arriving after a verdict and before the next new connection are
//   taken and dropped.
//   Result channel (m_valid/m_ready): a verdict item (kind 0), then for a
//   routing token one item per token byte (kind 1), up to TOKEN_BYTES of them;
//   last marks the final item of the packet.
// Timing:
//   One byte per cycle while parsing and the output register is free. A verdict
//   shows on the m_ side in the cycle after the byte that completes or breaks
//   the packet is taken. Token bytes are read back from the variable-part RAM,
//   one per cycle while the receiver does not stall; each goes through the
//   registered RAM read and then the output register, and the input is held
//   off until the last token byte is loaded. The RAM read port sets that readout rate.
// Reset: synchronous, active low; the parser then waits for a new connection.
// Stalls: a single output register holds the pending item; input bytes are
//   taken whenever that register is empty or being drained and no token is being read out.
`default_nettype none

`include "rdp_connection_request_token_parser_assert.svh"

module rdp_connection_request_token_parser #(
    parameter int TOKEN_BYTES = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input byte channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_new_connection,
    input  wire logic [7:0]  s_data_byte,
    // Result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_kind,
    output logic [1:0]       m_verdict,
    output logic [7:0]       m_token_byte,
    output logic [15:0]      m_token_length,
    output logic             m_truncated,
    output logic             m_last
);

    import rdptok_pkg::*;

    localparam int AW = $clog2(TOKEN_BYTES);
    localparam int CW = $clog2(TOKEN_BYTES + 1);
    localparam logic [15:0] TOKEN_MAX = 16'(TOKEN_BYTES);

    // Control and packet state
    rdptok_state_t state_reg, state_next;
    logic [15:0]   byte_offset_reg, byte_offset_next;
    logic [15:0]   packet_length_reg, packet_length_next;
    logic          finished_reg, finished_next;
    logic          crlf_seen_reg, crlf_seen_next;
    logic [15:0]   token_count_reg, token_count_next;
    logic          prior_cr_reg, prior_cr_next;
    logic          neg0_reg, neg0_next;
    logic          neg2_reg, neg2_next;
    logic          neg3_reg, neg3_next;

    // Token readout
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic [CW-1:0] tok_n_reg, tok_n_next;
    logic          rd_pend_reg, rd_pend_next;

    // Output register
    logic          m_valid_reg, m_valid_next;
    logic          m_kind_reg, m_kind_next;
    logic [1:0]    m_verdict_reg, m_verdict_next;
    logic [7:0]    m_token_byte_reg, m_token_byte_next;
    logic [15:0]   m_token_length_reg, m_token_length_next;
    logic          m_truncated_reg, m_truncated_next;
    logic          m_last_reg, m_last_next;

    // Byte decode
    logic          out_free;
    logic          accept;
    logic          active;
    logic [15:0]   off;
    logic [15:0]   plen_cur;
    logic          crlf_cur;
    logic          prior_cur;
    logic [15:0]   tc_cur;
    logic          bad;
    logic [15:0]   plen_new;
    logic          in_var;
    logic [15:0]   idx;
    logic          crlf_hit;
    logic          crlf_new;
    logic [15:0]   tc_new;
    logic          pkt_end;
    logic          neg;
    logic          token_verdict;
    logic          trunc_new;
    logic          token_start;

    // RAM ports
    logic          ram_wr_en;
    logic          ram_rd_en;
    logic          load_tok;
    logic [7:0]    ram_rd_data;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_RUN) && out_free;
    assign accept   = s_valid && s_ready;
    assign active   = accept && (s_new_connection || !finished_reg);

    // Per-packet state as seen by this byte (a new connection starts clean)
    assign off       = s_new_connection ? 16'd0 : byte_offset_reg;
    assign plen_cur  = s_new_connection ? 16'd0 : packet_length_reg;
    assign crlf_cur  = s_new_connection ? 1'b0  : crlf_seen_reg;
    assign prior_cur = s_new_connection ? 1'b0  : prior_cr_reg;
    assign tc_cur    = s_new_connection ? 16'd0 : token_count_reg;

    // Header checks and length capture
    always_comb begin
        bad      = 1'b0;
        plen_new = plen_cur;
        unique case (off)
            OFF_VERSION:  bad = (s_data_byte != TPKT_VERSION);
            OFF_RESERVED: bad = (s_data_byte != TPKT_RESERVED);
            OFF_LEN_HI:   plen_new = {s_data_byte, 8'h00};
            OFF_LEN_LO: begin
                plen_new = plen_cur | {8'h00, s_data_byte};
                bad      = (plen_new < MIN_PKT_LEN);
            end
            OFF_TPDU:     bad = (s_data_byte != X224_CR_CODE);
            default:      bad = 1'b0;
        endcase
    end

    // Variable part: CRLF search and packet end
    assign in_var    = (off >= OFF_VARIABLE);
    assign idx       = off - OFF_VARIABLE;
    assign crlf_hit  = in_var && !crlf_cur && prior_cur && (s_data_byte == CHAR_LF);
    assign crlf_new  = crlf_cur || crlf_hit;
    assign tc_new    = crlf_hit ? (idx - 16'd1) : tc_cur;
    assign pkt_end   = (off >= OFF_LAST_HDR) && (({1'b0, off} + 17'd1) == {1'b0, plen_new});
    assign neg       = (plen_new >= NEG_MIN_PKT) && neg0_reg && neg2_reg && neg3_reg;
    assign token_verdict = !neg && crlf_new && (tc_new != 16'd0);
    assign trunc_new = (tc_new > TOKEN_MAX);
    assign token_start = active && !bad && pkt_end && token_verdict;

    assign ram_wr_en = active && !bad && in_var && (idx < TOKEN_MAX);

    // Token readout: load pending RAM data, issue the next read
    assign load_tok  = (state_reg == S_TOKEN) && rd_pend_reg && out_free;
    assign ram_rd_en = (state_reg == S_TOKEN) && (rd_idx_reg < tok_n_reg)
                       && (!rd_pend_reg || load_tok);

    rdptok_ram #(
        .WIDTH (8),
        .DEPTH (TOKEN_BYTES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (idx[AW-1:0]),
        .wr_data (s_data_byte),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_idx_reg[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    // Next state and outputs
    always_comb begin
        state_next          = state_reg;
        byte_offset_next    = byte_offset_reg;
        packet_length_next  = packet_length_reg;
        finished_next       = finished_reg;
        crlf_seen_next      = crlf_seen_reg;
        token_count_next    = token_count_reg;
        prior_cr_next       = prior_cr_reg;
        neg0_next           = neg0_reg;
        neg2_next           = neg2_reg;
        neg3_next           = neg3_reg;
        rd_idx_next         = rd_idx_reg;
        tok_n_next          = tok_n_reg;
        rd_pend_next        = rd_pend_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_kind_next         = m_kind_reg;
        m_verdict_next      = m_verdict_reg;
        m_token_byte_next   = m_token_byte_reg;
        m_token_length_next = m_token_length_reg;
        m_truncated_next    = m_truncated_reg;
        m_last_next         = m_last_reg;

        unique case (state_reg)
            S_RUN: begin
                if (active) begin
                    packet_length_next = plen_new;
                    crlf_seen_next     = crlf_new;
                    token_count_next   = tc_new;
                    prior_cr_next      = (in_var && !crlf_cur) ?
                                         (s_data_byte == CHAR_CR) : prior_cur;
                    byte_offset_next   = off + 16'd1;
                    finished_next      = 1'b0;
                    if (in_var && idx == 16'd0) begin
                        neg0_next = (s_data_byte == NEG_TYPE);
                    end
                    if (in_var && idx == 16'd2) begin
                        neg2_next = (s_data_byte == NEG_LEN_LO);
                    end
                    if (in_var && idx == 16'd3) begin
                        neg3_next = (s_data_byte == NEG_LEN_HI);
                    end
                    if (bad || pkt_end) begin
                        finished_next       = 1'b1;
                        byte_offset_next    = off;
                        m_valid_next        = 1'b1;
                        m_kind_next         = KIND_VERDICT;
                        m_token_byte_next   = 8'h00;
                        m_verdict_next      = VERDICT_MALFORMED;
                        m_token_length_next = 16'd0;
                        m_truncated_next    = 1'b0;
                        m_last_next         = 1'b1;
                        if (!bad) begin
                            m_verdict_next = VERDICT_NORMAL;
                            if (token_verdict) begin
                                m_verdict_next      = VERDICT_TOKEN;
                                m_token_length_next = tc_new;
                                m_truncated_next    = trunc_new;
                                m_last_next         = 1'b0;
                                tok_n_next          = trunc_new ? CW'(TOKEN_BYTES)
                                                                : tc_new[CW-1:0];
                                rd_idx_next         = '0;
                                rd_pend_next        = 1'b0;
                                state_next          = S_TOKEN;
                            end
                        end
                    end
                end
            end
            S_TOKEN: begin
                if (ram_rd_en) begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                end
                rd_pend_next = ram_rd_en || (rd_pend_reg && !load_tok);
                if (load_tok) begin
                    m_valid_next      = 1'b1;
                    m_kind_next       = KIND_TOKEN;
                    m_token_byte_next = ram_rd_data;
                    m_last_next       = (rd_idx_reg == tok_n_reg);
                    if (rd_idx_reg == tok_n_reg) begin
                        state_next = S_RUN;
                    end
                end
            end
            default: state_next = S_RUN;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_RUN;
            byte_offset_reg   <= '0;
            packet_length_reg <= '0;
            finished_reg      <= 1'b1;
            crlf_seen_reg     <= 1'b0;
            token_count_reg   <= '0;
            prior_cr_reg      <= 1'b0;
            rd_idx_reg        <= '0;
            tok_n_reg         <= '0;
            rd_pend_reg       <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            byte_offset_reg   <= byte_offset_next;
            packet_length_reg <= packet_length_next;
            finished_reg      <= finished_next;
            crlf_seen_reg     <= crlf_seen_next;
            token_count_reg   <= token_count_next;
            prior_cr_reg      <= prior_cr_next;
            rd_idx_reg        <= rd_idx_next;
            tok_n_reg         <= tok_n_next;
            rd_pend_reg       <= rd_pend_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        neg0_reg           <= neg0_next;
        neg2_reg           <= neg2_next;
        neg3_reg           <= neg3_next;
        m_kind_reg         <= m_kind_next;
        m_verdict_reg      <= m_verdict_next;
        m_token_byte_reg   <= m_token_byte_next;
        m_token_length_reg <= m_token_length_next;
        m_truncated_reg    <= m_truncated_next;
        m_last_reg         <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_verdict      = m_verdict_reg;
    assign m_token_byte   = m_token_byte_reg;
    assign m_token_length = m_token_length_reg;
    assign m_truncated    = m_truncated_reg;
    assign m_last         = m_last_reg;

    // Checks
    `RDPTOK_ASSERT_NOW(a_rd_idx_bound, aclk, aresetn,
        state_reg == S_TOKEN, rd_idx_reg <= tok_n_reg)
    `RDPTOK_ASSERT_NOW(a_pend_in_token, aclk, aresetn,
        rd_pend_reg, state_reg == S_TOKEN)
    `RDPTOK_ASSERT_NEXT(a_token_verdict_first, aclk, aresetn,
        token_start, m_valid && m_kind == KIND_VERDICT && !m_last)
    `RDPTOK_ASSERT_NOW(a_token_item_verdict, aclk, aresetn,
        m_valid_reg && m_kind_reg == KIND_TOKEN, m_verdict_reg == VERDICT_TOKEN)

endmodule

`default_nettype wire

// ----- rtl/rdptok_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module rdptok_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire
